/* rtl/tmcn_pkg.sv */
// ============================================================================
// tmcn_pkg: shared types and constants for the tet10 cell node id unit
// Field widths, register indexes, the five-tetrahedra corner tables and the
// helper that gives the half-step offset of each of the ten tet10 nodes.
// ============================================================================
package tmcn_pkg;

    localparam int COORD_W              = 8;
    localparam int CNT_W                = 9;
    localparam int ID_W                 = 27;
    localparam int TET_W                = 3;
    localparam int TETS_PER_CELL        = 5;
    localparam int NODES_PER_TET        = 10;
    localparam int CORNERS_PER_TET      = 4;
    localparam int CFG_IDX_W            = 2;
    localparam int XOFF_W               = COORD_W + 2;
    localparam int MAX_CELLS_DEFAULT    = 256;
    localparam int QUEUE_DEPTH_DEFAULT  = 4;

    localparam logic [TET_W-1:0] TET_LAST = TET_W'(TETS_PER_CELL - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELLS_X = 2'd0,
        REG_CELLS_Y = 2'd1,
        REG_CELLS_Z = 2'd2
    } cfg_reg_t;

    // Half-step offset of a node from the low corner of its cell, 0..2 per axis.
    typedef struct packed {
        logic [1:0] dx;
        logic [1:0] dy;
        logic [1:0] dz;
    } step_t;

    // Id offsets indexed by [dz][dy]; they depend only on the grid size.
    typedef struct packed {
        logic [0:2][0:2][ID_W-1:0] off;
    } geo_t;

    // One classified cell waiting for the back end.
    typedef struct packed {
        logic [ID_W-1:0]    zya;
        logic [ID_W-1:0]    zyb;
        logic [COORD_W-1:0] cx;
        logic               pat;
    } cell_entry_t;

    // Corner unit steps, bits {x, y, z}, indexed [pattern][tet][corner].
    localparam logic [2:0] CORNER_TAB [0:1][0:TETS_PER_CELL-1][0:CORNERS_PER_TET-1] = '{
        '{
            '{3'b000, 3'b100, 3'b010, 3'b001},
            '{3'b100, 3'b111, 3'b001, 3'b101},
            '{3'b100, 3'b010, 3'b111, 3'b110},
            '{3'b111, 3'b010, 3'b001, 3'b011},
            '{3'b111, 3'b100, 3'b001, 3'b010}
        },
        '{
            '{3'b000, 3'b100, 3'b110, 3'b101},
            '{3'b110, 3'b011, 3'b101, 3'b111},
            '{3'b000, 3'b011, 3'b110, 3'b010},
            '{3'b000, 3'b101, 3'b011, 3'b001},
            '{3'b101, 3'b011, 3'b110, 3'b000}
        }
    };

    // Corner pairs of the edge midpoints, nodes 4 to 9.
    localparam logic [1:0] EDGE_P [0:5] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] EDGE_Q [0:5] = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd3, 2'd3};

    function automatic step_t node_step(logic pat, logic [TET_W-1:0] tet, logic [3:0] node);
        logic [2:0] p;
        logic [2:0] q;
        logic [2:0] e;
        step_t      s;
        if (node < 4'd4)
        begin
            p    = CORNER_TAB[pat][tet][node[1:0]];
            s.dx = {p[2], 1'b0};
            s.dy = {p[1], 1'b0};
            s.dz = {p[0], 1'b0};
        end
        else
        begin
            e    = 3'(node - 4'd4);
            p    = CORNER_TAB[pat][tet][EDGE_P[e]];
            q    = CORNER_TAB[pat][tet][EDGE_Q[e]];
            s.dx = {1'b0, p[2]} + {1'b0, q[2]};
            s.dy = {1'b0, p[1]} + {1'b0, q[1]};
            s.dz = {1'b0, p[0]} + {1'b0, q[0]};
        end
        return s;
    endfunction

endpackage

/* rtl/tmcn_if.sv */
// ============================================================================
// tmcn_if: item channels of the tet10 cell node id unit
// Valid/ready channels for the cell coordinates and the tetrahedron results.
// ============================================================================
interface tmcn_cell_if import tmcn_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;

    modport source (output valid, output cell_x, output cell_y, output cell_z, input ready);
    modport sink   (input valid, input cell_x, input cell_y, input cell_z, output ready);
endinterface

interface tmcn_tet_if import tmcn_pkg::*;;
    logic             valid;
    logic             ready;
    logic [TET_W-1:0] tet_index;
    logic [ID_W-1:0]  node_0;
    logic [ID_W-1:0]  node_1;
    logic [ID_W-1:0]  node_2;
    logic [ID_W-1:0]  node_3;
    logic [ID_W-1:0]  node_4;
    logic [ID_W-1:0]  node_5;
    logic [ID_W-1:0]  node_6;
    logic [ID_W-1:0]  node_7;
    logic [ID_W-1:0]  node_8;
    logic [ID_W-1:0]  node_9;
    logic             last;

    modport source (output valid, output tet_index, output node_0, output node_1,
                    output node_2, output node_3, output node_4, output node_5,
                    output node_6, output node_7, output node_8, output node_9,
                    output last, input ready);
    modport sink   (input valid, input tet_index, input node_0, input node_1,
                    input node_2, input node_3, input node_4, input node_5,
                    input node_6, input node_7, input node_8, input node_9,
                    input last, output ready);
endinterface

/* rtl/tmcn_front.sv */
// ============================================================================
// tmcn_front: configuration, range check and per-cell base ids
// Holds the grid size, derives the id strides, drops cells outside the grid
// and works out the per-cell base ids in a four-stage stalling pipeline.
// ============================================================================
module tmcn_front import tmcn_pkg::*;
#(
    parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    tmcn_cell_if.sink            cells,
    output logic                 push,
    output cell_entry_t          push_data,
    input  logic                 q_full,
    output geo_t                 geo
);

    localparam int WX_W  = CNT_W + 1;
    localparam int WXY_W = 2 * WX_W;
    localparam int GXY_W = 2 * CNT_W;
    localparam int ZW_W  = COORD_W + WXY_W;
    localparam int ZG_W  = COORD_W + GXY_W;
    localparam int YW_W  = COORD_W + WX_W;
    localparam int YG_W  = COORD_W + CNT_W;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP = (MAX_CELLS_PER_AXIS > CNT_MAX) ? CNT_MAX : MAX_CELLS_PER_AXIS;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    logic [CNT_W-1:0] cells_x_reg;
    logic [CNT_W-1:0] cells_y_reg;
    logic [CNT_W-1:0] cells_z_reg;
    logic [CNT_W-1:0] gx;
    logic [CNT_W-1:0] gy;
    logic [CNT_W-1:0] gz;

    logic [CNT_W-1:0] gx_reg;
    logic [WX_W-1:0]  wx_reg;
    logic [WXY_W-1:0] wxy_reg;
    logic [GXY_W-1:0] gxy_reg;
    geo_t             geo_reg;
    geo_t             geo_next;

    logic             en;
    logic             in_range;

    logic               s1_v_reg;
    logic               s2_v_reg;
    logic               s3_v_reg;
    logic               s4_v_reg;
    logic [COORD_W-1:0] s1_cx_reg;
    logic [COORD_W-1:0] s1_cy_reg;
    logic [COORD_W-1:0] s1_cz_reg;
    logic               s1_pat_reg;
    logic [COORD_W-1:0] s2_cx_reg;
    logic               s2_pat_reg;
    logic [ID_W-1:0]    s2_zw_reg;
    logic [ID_W-1:0]    s2_zg_reg;
    logic [ID_W-1:0]    s2_yw_reg;
    logic [ID_W-1:0]    s2_yg_reg;
    logic [COORD_W-1:0] s3_cx_reg;
    logic               s3_pat_reg;
    logic [ID_W-1:0]    s3_zb_reg;
    logic [ID_W-1:0]    s3_ya_reg;
    logic [ID_W-1:0]    s3_yb_reg;
    cell_entry_t        s4_reg;

    logic [ZW_W-1:0]  zw_prod;
    logic [ZG_W-1:0]  zg_prod;
    logic [YW_W-1:0]  yw_prod;
    logic [YG_W-1:0]  yg_prod;

    logic [ID_W-1:0]  zoff [0:2];
    logic [ID_W-1:0]  yoff_even [0:2];
    logic [ID_W-1:0]  yoff_odd [0:2];

    // Grid size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= CNT_W'(1);
            cells_y_reg <= CNT_W'(1);
            cells_z_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELLS_X: cells_x_reg <= cfg_data;
                REG_CELLS_Y: cells_y_reg <= cfg_data;
                REG_CELLS_Z: cells_z_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign gx = (cells_x_reg > CAP_CNT) ? CAP_CNT : cells_x_reg;
    assign gy = (cells_y_reg > CAP_CNT) ? CAP_CNT : cells_y_reg;
    assign gz = (cells_z_reg > CAP_CNT) ? CAP_CNT : cells_z_reg;

    // Strides are recomputed every cycle; geo_reg registers the offsets after them.
    always_ff @(posedge clk)
    begin
        gx_reg  <= gx;
        wx_reg  <= {gx, 1'b1};
        wxy_reg <= {{WX_W{1'b0}}, gx, 1'b1} * {{WX_W{1'b0}}, gy, 1'b1};
        gxy_reg <= {{CNT_W{1'b0}}, gx} * {{CNT_W{1'b0}}, gy};
        geo_reg <= geo_next;
    end

    // Offset for half step dz along z plus dy along y. An odd z half step
    // skips the cell centres of its layer, which shortens the y stride.
    always_comb
    begin
        zoff[0]      = '0;
        zoff[1]      = ID_W'(wxy_reg);
        zoff[2]      = (ID_W'(wxy_reg) << 1) - ID_W'(gxy_reg);
        yoff_even[0] = '0;
        yoff_even[1] = ID_W'(wx_reg);
        yoff_even[2] = ID_W'(wx_reg) << 1;
        yoff_odd[0]  = '0;
        yoff_odd[1]  = ID_W'(wx_reg);
        yoff_odd[2]  = (ID_W'(wx_reg) << 1) - ID_W'(gx_reg);
        for (int dz = 0; dz < 3; dz++)
        begin
            for (int dy = 0; dy < 3; dy++)
            begin
                geo_next.off[dz][dy] = zoff[dz] + ((dz == 1) ? yoff_odd[dy] : yoff_even[dy]);
            end
        end
    end

    assign geo = geo_reg;

    assign en          = !s4_v_reg || !q_full;
    assign cells.ready = en;
    assign push        = s4_v_reg && !q_full;
    assign push_data   = s4_reg;

    assign in_range = ({1'b0, cells.cell_x} < gx) &&
                      ({1'b0, cells.cell_y} < gy) &&
                      ({1'b0, cells.cell_z} < gz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= cells.valid && in_range;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    assign zw_prod = {{(ZW_W-COORD_W){1'b0}}, s1_cz_reg} * {{(ZW_W-WXY_W){1'b0}}, wxy_reg};
    assign zg_prod = {{(ZG_W-COORD_W){1'b0}}, s1_cz_reg} * {{(ZG_W-GXY_W){1'b0}}, gxy_reg};
    assign yw_prod = {{(YW_W-COORD_W){1'b0}}, s1_cy_reg} * {{(YW_W-WX_W){1'b0}}, wx_reg};
    assign yg_prod = {{(YG_W-COORD_W){1'b0}}, s1_cy_reg} * {{(YG_W-CNT_W){1'b0}}, gx_reg};

    // Ids wrap at the id width, so all sums run modulo 2**ID_W.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cx_reg  <= cells.cell_x;
            s1_cy_reg  <= cells.cell_y;
            s1_cz_reg  <= cells.cell_z;
            s1_pat_reg <= cells.cell_x[0] ^ cells.cell_y[0] ^ cells.cell_z[0];

            s2_cx_reg  <= s1_cx_reg;
            s2_pat_reg <= s1_pat_reg;
            s2_zw_reg  <= ID_W'(zw_prod);
            s2_zg_reg  <= ID_W'(zg_prod);
            s2_yw_reg  <= ID_W'(yw_prod);
            s2_yg_reg  <= ID_W'(yg_prod);

            s3_cx_reg  <= s2_cx_reg;
            s3_pat_reg <= s2_pat_reg;
            s3_zb_reg  <= (s2_zw_reg << 1) - s2_zg_reg;
            s3_ya_reg  <= s2_yw_reg << 1;
            s3_yb_reg  <= (s2_yw_reg << 1) - s2_yg_reg;

            s4_reg.zya <= s3_zb_reg + s3_ya_reg;
            s4_reg.zyb <= s3_zb_reg + s3_yb_reg;
            s4_reg.cx  <= s3_cx_reg;
            s4_reg.pat <= s3_pat_reg;
        end
    end

    a_drop_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (cells.valid && cells.ready && !in_range) |=> !s1_v_reg)
        else $error("cell outside the grid entered the pipeline");

    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_v_reg && q_full) |=> (s4_v_reg && $stable(s4_reg)))
        else $error("classified cell lost while the queue was full");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && en) |=> s3_v_reg)
        else $error("cell dropped between pipeline stages");

endmodule

/* rtl/tmcn_queue.sv */
// ============================================================================
// tmcn_queue: short queue between front and back end
// Register-based FIFO of classified cells with a fill count.
// ============================================================================
module tmcn_queue import tmcn_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cell_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output cell_entry_t head,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    cell_entry_t        mem [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_QW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_QW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue fill count out of range");

endmodule

/* rtl/tmcn_back.sv */
// ============================================================================
// tmcn_back: tetrahedron sequencer and node id adders
// Walks the five tetrahedra of the cell at the queue head, one per cycle unless
// stalled, and forms ten node ids in two adder stages, b1 then out_node_reg.
// ============================================================================
module tmcn_back import tmcn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_entry_t head,
    input  logic        empty,
    output logic        pop,
    input  geo_t        geo,
    tmcn_tet_if.source  tets
);

    logic             en;
    logic             load;
    logic [TET_W-1:0] tet_reg;

    step_t              steps [0:NODES_PER_TET-1];
    logic [ID_W-1:0]    a_next [0:NODES_PER_TET-1];
    logic [XOFF_W-1:0]  x_next [0:NODES_PER_TET-1];
    logic [XOFF_W-1:0]  cx_ext;

    logic               b1_v_reg;
    logic [TET_W-1:0]   b1_tet_reg;
    logic [ID_W-1:0]    b1_a_reg [0:NODES_PER_TET-1];
    logic [XOFF_W-1:0]  b1_x_reg [0:NODES_PER_TET-1];

    logic               out_v_reg;
    logic [TET_W-1:0]   out_tet_reg;
    logic [ID_W-1:0]    out_node_reg [0:NODES_PER_TET-1];

    assign en   = !out_v_reg || tets.ready;
    assign load = en && !empty;
    assign pop  = load && (tet_reg == TET_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tet_reg   <= '0;
            b1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                tet_reg <= (tet_reg == TET_LAST) ? '0 : tet_reg + TET_W'(1);
            end
            if (en)
            begin
                b1_v_reg  <= load;
                out_v_reg <= b1_v_reg;
            end
        end
    end

    // The x part of an id drops the cell centres before it when both the
    // y and z half steps are odd.
    assign cx_ext = XOFF_W'(head.cx);

    always_comb
    begin
        for (int n = 0; n < NODES_PER_TET; n++)
        begin
            steps[n]  = node_step(head.pat, tet_reg, 4'(n));
            a_next[n] = ((steps[n].dz == 2'd1) ? head.zyb : head.zya) +
                        geo.off[steps[n].dz][steps[n].dy];
            if (steps[n].dy == 2'd1 && steps[n].dz == 2'd1)
            begin
                x_next[n] = cx_ext + XOFF_W'(steps[n].dx != 2'd0);
            end
            else
            begin
                x_next[n] = (cx_ext << 1) + XOFF_W'(steps[n].dx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_tet_reg  <= tet_reg;
            out_tet_reg <= b1_tet_reg;
            for (int n = 0; n < NODES_PER_TET; n++)
            begin
                b1_a_reg[n]     <= a_next[n];
                b1_x_reg[n]     <= x_next[n];
                out_node_reg[n] <= b1_a_reg[n] + ID_W'(b1_x_reg[n]);
            end
        end
    end

    assign tets.valid     = out_v_reg;
    assign tets.tet_index = out_tet_reg;
    assign tets.node_0    = out_node_reg[0];
    assign tets.node_1    = out_node_reg[1];
    assign tets.node_2    = out_node_reg[2];
    assign tets.node_3    = out_node_reg[3];
    assign tets.node_4    = out_node_reg[4];
    assign tets.node_5    = out_node_reg[5];
    assign tets.node_6    = out_node_reg[6];
    assign tets.node_7    = out_node_reg[7];
    assign tets.node_8    = out_node_reg[8];
    assign tets.node_9    = out_node_reg[9];
    assign tets.last      = (out_tet_reg == TET_LAST);

    a_tet_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tet_reg <= TET_LAST)
        else $error("tetrahedron counter out of range");

    a_tet_order: assert property (@(posedge clk) disable iff (!rst_n)
        (en && b1_v_reg && out_v_reg) |=>
        (out_tet_reg == (($past(out_tet_reg) == TET_LAST) ? '0 :
                         $past(out_tet_reg) + TET_W'(1))))
        else $error("tetrahedra of a cell delivered out of order");

    a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && tet_reg != TET_LAST) |=> (!empty))
        else $error("cell left the queue before its last tetrahedron");

endmodule

/* rtl/tet_mesh_cell_node_ids_unit.sv */
// ============================================================================
// tet_mesh_cell_node_ids_unit: five-tetrahedra tet10 split of a grid cell
// Top level: front end, cell queue and tetrahedron back end.
// ============================================================================
// Each accepted cell that lies inside the grid gives five result items, one
// per tetrahedron, tet_index 0 to 4 with last set on the fifth; a cell outside
// the grid, or any cell while a cell count is zero, gives none. The back end
// forms one tetrahedron per cycle while its output is not stalled and pops a
// cell on taking its fifth; the input takes one cell per cycle while the queue
// between front and back end has room, as do cells outside the grid. A cell
// passes the four front stages, the queue, b1 and the output register before
// its first result. The user must write the grid size registers through cfg_we,
// cfg_index and cfg_data only while the unit is idle; the unit does not enforce
// this. Counts above MAX_CELLS_PER_AXIS are treated as that maximum.
module tet_mesh_cell_node_ids_unit import tmcn_pkg::*;
#(
    parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEFAULT,
    parameter int QUEUE_DEPTH        = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    tmcn_cell_if.sink            cells,
    tmcn_tet_if.source           tets
);

    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    cell_entry_t push_data;
    cell_entry_t q_head;
    geo_t        geo;

    tmcn_front #(
        .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cells),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full),
        .geo       (geo)
    );

    tmcn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    tmcn_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .empty (q_empty),
        .pop   (pop),
        .geo   (geo),
        .tets  (tets)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the tet10 cell node id unit
// Sends grid cells over the cell channel, predicts the five tetrahedra of
// each cell inside the grid and checks every result item field by field.
// ============================================================================
module tb_top;
    import tmcn_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_EXTENT    = MAX_CELLS_DEFAULT;

    // Index two bits wide but not tied to any grid register.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Corner unit steps {x, y, z}: [odd coordinate sum][tetrahedron][corner].
    localparam logic [2:0] SPLIT_CORNERS [0:1][0:4][0:3] = '{
        '{
            '{3'b000, 3'b100, 3'b010, 3'b001},
            '{3'b100, 3'b111, 3'b001, 3'b101},
            '{3'b100, 3'b010, 3'b111, 3'b110},
            '{3'b111, 3'b010, 3'b001, 3'b011},
            '{3'b111, 3'b100, 3'b001, 3'b010}
        },
        '{
            '{3'b000, 3'b100, 3'b110, 3'b101},
            '{3'b110, 3'b011, 3'b101, 3'b111},
            '{3'b000, 3'b011, 3'b110, 3'b010},
            '{3'b000, 3'b101, 3'b011, 3'b001},
            '{3'b101, 3'b011, 3'b110, 3'b000}
        }
    };
    localparam int EDGE_FROM [0:5] = '{0, 1, 2, 0, 1, 2};
    localparam int EDGE_TO   [0:5] = '{1, 2, 0, 3, 3, 3};

    typedef struct packed {
        logic [TET_W-1:0]           tet;
        logic [9:0][ID_W-1:0]       node;
        logic                       last;
    } tet_ids_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0] cfg_data;

    tmcn_cell_if cells ();
    tmcn_tet_if  tets ();

    tet_mesh_cell_node_ids_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cells),
        .tets      (tets)
    );

    // Grid counts as the unit holds them.
    logic [CNT_W-1:0] grid_x;
    logic [CNT_W-1:0] grid_y;
    logic [CNT_W-1:0] grid_z;

    tet_ids_t pending_tets [$];
    int error_count;
    int cells_sent;
    int cells_inside;
    int tets_checked;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        tets.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    function automatic int unsigned clamp_extent(logic [CNT_W-1:0] cnt);
        return (cnt > MAX_EXTENT) ? MAX_EXTENT : cnt;
    endfunction

    // Id of a half-step lattice point; cell centres are left out of the count.
    function automatic logic [ID_W-1:0] lattice_id(longint unsigned hx, longint unsigned hy,
                                                   longint unsigned hz, longint unsigned gx,
                                                   longint unsigned gy);
        longint unsigned xc;
        longint unsigned yc;
        longint unsigned zc;
        longint unsigned sum;
        xc  = ((hy & 1) != 0 && (hz & 1) != 0) ? hx / 2 : 0;
        yc  = ((hz & 1) != 0) ? (hy / 2) * gx : 0;
        zc  = (hz / 2) * gx * gy;
        sum = (hx - xc) + (hy * (2 * gx + 1) - yc)
              + (hz * (2 * gy + 1) * (2 * gx + 1) - zc);
        return sum[ID_W-1:0];
    endfunction

    task automatic split_cell(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z);
        int unsigned gx;
        int unsigned gy;
        int unsigned gz;
        logic        odd;
        logic [2:0]  a;
        logic [2:0]  b;
        tet_ids_t    r;
        gx = clamp_extent(grid_x);
        gy = clamp_extent(grid_y);
        gz = clamp_extent(grid_z);
        if (x >= gx || y >= gy || z >= gz)
            return;
        cells_inside++;
        odd = x[0] ^ y[0] ^ z[0];
        for (int t = 0; t < TETS_PER_CELL; t++)
        begin
            r.tet  = TET_W'(t);
            r.last = (t == TETS_PER_CELL - 1);
            for (int k = 0; k < 4; k++)
            begin
                a = SPLIT_CORNERS[odd][t][k];
                r.node[k] = lattice_id(2 * x + 2 * a[2], 2 * y + 2 * a[1], 2 * z + 2 * a[0],
                                       gx, gy);
            end
            for (int e = 0; e < 6; e++)
            begin
                a = SPLIT_CORNERS[odd][t][EDGE_FROM[e]];
                b = SPLIT_CORNERS[odd][t][EDGE_TO[e]];
                r.node[4 + e] = lattice_id(2 * x + a[2] + b[2], 2 * y + a[1] + b[1],
                                           2 * z + a[0] + b[0], gx, gy);
            end
            pending_tets = {pending_tets, r};
        end
    endtask

    // Valid is left high after an item so that back-to-back items never
    // lower and raise it in one step; cells_quiet drops it after a batch.
    task automatic send_cell(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            cells.valid <= 1'b0;
            @(posedge clk);
        end
        cells.valid  <= 1'b1;
        cells.cell_x <= x;
        cells.cell_y <= y;
        cells.cell_z <= z;
        @(posedge clk);
        while (!cells.ready)
            @(posedge clk);
        cells_sent++;
        split_cell(x, y, z);
    endtask

    task automatic cells_quiet();
        cells.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_tets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_CELLS_X: grid_x = val;
            REG_CELLS_Y: grid_y = val;
            REG_CELLS_Z: grid_z = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [CNT_W-1:0] gx, input logic [CNT_W-1:0] gy,
                            input logic [CNT_W-1:0] gz);
        write_reg(REG_CELLS_X, gx);
        write_reg(REG_CELLS_Y, gy);
        write_reg(REG_CELLS_Z, gz);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] pick_extent();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return CNT_W'($urandom_range(6, 1));
        else if (sel < 8)
            return CNT_W'($urandom_range(MAX_EXTENT, 1));
        else if (sel == 8)
            return CNT_W'(MAX_EXTENT);
        return CNT_W'($urandom_range(511, MAX_EXTENT + 1));
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(logic [CNT_W-1:0] cnt);
        int unsigned g;
        g = clamp_extent(cnt);
        if (g == 0 || $urandom_range(99) < 15)
            return COORD_W'($urandom_range(255));
        return COORD_W'($urandom_range(g - 1, 0));
    endfunction

    always @(posedge clk)
    begin : check_tets
        tet_ids_t got;
        tet_ids_t want;
        if (rst_n && tets.valid && tets.ready)
        begin
            got.tet  = tets.tet_index;
            got.node = {tets.node_9, tets.node_8, tets.node_7, tets.node_6, tets.node_5,
                        tets.node_4, tets.node_3, tets.node_2, tets.node_1, tets.node_0};
            got.last = tets.last;
            if (pending_tets.size() == 0)
            begin
                $display("%0t: unexpected item tet_index %0d node_0 %0d", $time,
                         got.tet, got.node[0]);
                error_count++;
            end
            else
            begin
                want = pending_tets.pop_front();
                tets_checked++;
                if (got.tet !== want.tet)
                begin
                    $display("%0t: tet_index expected %0d actual %0d", $time, want.tet, got.tet);
                    error_count++;
                end
                for (int n = 0; n < 10; n++)
                begin
                    if (got.node[n] !== want.node[n])
                    begin
                        $display("%0t: tet %0d node_%0d expected %0d actual %0d", $time,
                                 want.tet, n, want.node[n], got.node[n]);
                        error_count++;
                    end
                end
                if (got.last !== want.last)
                begin
                    $display("%0t: tet %0d last expected %0b actual %0b", $time,
                             want.tet, want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Grid of one cell as it comes out of reset.
    task automatic test_reset_grid();
        send_cell(0, 0, 0);
        send_cell(1, 0, 0);
        send_cell(0, 0, 1);
        send_cell(255, 255, 255);
        cells_quiet();
        wait_idle();
    endtask

    task automatic test_full_grid_corners();
        set_grid(MAX_EXTENT, MAX_EXTENT, MAX_EXTENT);
        send_cell(0, 0, 0);
        send_cell(255, 255, 255);
        send_cell(255, 0, 0);
        send_cell(0, 255, 0);
        send_cell(0, 0, 255);
        send_cell(1, 0, 0);
        cells_quiet();
        wait_idle();
    endtask

    // Both patterns inside a small grid, then one step past each axis.
    task automatic test_small_grid_bounds();
        set_grid(3, 2, 4);
        send_cell(2, 1, 3);
        send_cell(1, 1, 3);
        send_cell(3, 0, 0);
        send_cell(0, 2, 0);
        send_cell(0, 0, 4);
        cells_quiet();
        wait_idle();
    endtask

    task automatic test_zero_and_saturation();
        set_grid(5, 0, 5);
        send_cell(0, 0, 0);
        cells_quiet();
        wait_idle();
        write_reg(REG_CELLS_X, 511);
        write_reg(REG_CELLS_Y, 300);
        write_reg(REG_CELLS_Z, MAX_EXTENT + 1);
        write_reg(REG_SPARE, 0);
        cfg_we <= 1'b0;
        send_cell(255, 255, 255);
        send_cell(170, 85, 254);
        cells_quiet();
        wait_idle();
    endtask

    // Halfway through, the sender holds off until every result is back and
    // the grid is changed.
    task automatic test_random_stream(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        set_grid(pick_extent(), pick_extent(), pick_extent());
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                cells_quiet();
                wait_idle();
                set_grid(pick_extent(), pick_extent(), pick_extent());
            end
            send_cell(pick_coord(grid_x), pick_coord(grid_y), pick_coord(grid_z));
        end
        cells_quiet();
        wait_idle();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_CELLS_X;
        cfg_data       = '0;
        cells.valid    = 1'b0;
        cells.cell_x   = '0;
        cells.cell_y   = '0;
        cells.cell_z   = '0;
        tets.ready     = 1'b0;
        grid_x         = 1;
        grid_y         = 1;
        grid_z         = 1;
        error_count    = 0;
        cells_sent     = 0;
        cells_inside   = 0;
        tets_checked   = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_grid();
        test_full_grid_corners();
        test_small_grid_bounds();
        test_zero_and_saturation();
        test_random_stream(0, 0, 88);
        test_random_stream(83, 0, 88);
        test_random_stream(0, 83, 88);
        test_random_stream(37, 37, 88);

        $display("Sent %0d cells, %0d inside the grid; checked %0d tetrahedra.",
                 cells_sent, cells_inside, tets_checked);
        $display("Grids ranged from empty and single-cell to saturated counts.");
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
